// File: design/bmorph_pkg.sv
// Shared types and constants for the 3x3 binary morphology block.
package bmorph_pkg;

  localparam int PIXEL_W      = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_W     = 16;
  // Row counter runs one past the image height while the last row drains.
  localparam int ROW_W        = HEIGHT_W + 1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [PIXEL_W-1:0] PIXEL_SET   = 8'd255;
  localparam logic [PIXEL_W-1:0] PIXEL_CLEAR = 8'd0;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic OP_ERODE  = 1'b0;
  localparam logic OP_DILATE = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_OP_MODE         = 2'd2,
    CFG_EIGHT_CONNECTED = 2'd3
  } cfg_reg_t;

  // Per-item control passed from the scan counters to the window stage.
  typedef struct packed {
    logic bit_set;
    logic has_result;
    logic edge_top;
    logic edge_bottom;
    logic edge_left;
    logic edge_right;
    logic last;
  } tag_t;

endpackage

// File: design/bmorph_scan.sv
// Raster scan counters: classify each accepted item and locate its result.
module bmorph_scan #(
  parameter int CW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            restart,
  input  logic                            req_type,
  input  logic [bmorph_pkg::PIXEL_W-1:0]  pixel_in,
  input  logic [CW-1:0]                   w_last,
  input  logic [bmorph_pkg::HEIGHT_W-1:0] h_eff,
  output logic                            load,
  output logic [CW-1:0]                   rd_addr,
  output bmorph_pkg::tag_t                tag
);

  logic [CW-1:0]                in_column;
  logic [CW-1:0]                in_column_next;
  logic [bmorph_pkg::ROW_W-1:0] in_row;
  logic [bmorph_pkg::ROW_W-1:0] in_row_next;
  logic [bmorph_pkg::ROW_W-1:0] h_ext;
  logic [bmorph_pkg::ROW_W-1:0] h_plus1;
  logic                         draining;
  logic                         col_zero;
  logic                         from_row_end;
  logic                         from_mid_row;

  assign h_ext    = {1'b0, h_eff};
  assign h_plus1  = h_ext + 17'd1;
  assign draining = in_row >= h_ext;
  assign col_zero = in_column == '0;

  // A drain before the frame has fully arrived is dropped on the floor.
  assign load    = accept && !((req_type == bmorph_pkg::REQ_DRAIN) && !draining);
  assign rd_addr = in_column;

  // Column zero finishes the right-hand pixel of the row two above;
  // any other column finishes the pixel one row up and one column left.
  assign from_row_end = col_zero && (in_row >= 17'd2);
  assign from_mid_row = !col_zero && (in_row != '0);

  always_comb begin
    tag.bit_set     = !draining && (pixel_in == bmorph_pkg::PIXEL_SET);
    tag.has_result  = from_row_end || from_mid_row;
    tag.edge_top    = from_row_end ? (in_row == 17'd2) : (in_row == 17'd1);
    tag.edge_bottom = from_row_end ? (in_row == h_plus1) : draining;
    tag.edge_left   = from_row_end ? (w_last == '0) : (in_column == CW'(1));
    tag.edge_right  = from_row_end;
    tag.last        = from_row_end && (in_row == h_plus1);
  end

  always_comb begin
    in_column_next = in_column;
    in_row_next    = in_row;
    if (restart) begin
      in_column_next = '0;
      in_row_next    = '0;
    end else if (load) begin
      if (tag.last) begin
        in_column_next = '0;
        in_row_next    = '0;
      end else if (in_column == w_last) begin
        in_column_next = '0;
        in_row_next    = in_row + 17'd1;
      end else begin
        in_column_next = in_column + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    in_column <= w_last)
    else $error("column counter beyond row end");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    load && tag.last |=> in_column == '0 && in_row == '0)
    else $error("counters not cleared after frame end");

endmodule

// File: design/bmorph_line_buf.sv
// Two one-bit line buffers packed in one memory, with read-during-write bypass.
module bmorph_line_buf #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [CW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic          wr_bit,
  output logic          rd_two,
  output logic          rd_above
);

  // bit 1: row two above, bit 0: row above
  logic [1:0]    mem [MAX_WIDTH];
  logic [1:0]    rdata;
  logic [1:0]    wdata;
  logic [CW-1:0] addr_q;

  // The row above moves down to two above, the new pixel becomes the row above.
  assign wdata    = {rdata[0], wr_bit};
  assign rd_two   = rdata[1];
  assign rd_above = rdata[0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q <= rd_addr;
      if (wr_en && (addr_q == rd_addr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[rd_addr];
      end
    end
  end

endmodule

// File: design/bmorph_window.sv
// 3x3 window stage: shifts in one column per item, evaluates, registers the result.
module bmorph_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  bmorph_pkg::tag_t               tag,
  input  logic                           restart,
  input  logic                           rd_two,
  input  logic                           rd_above,
  input  logic                           op_mode,
  input  logic                           eight_connected,
  input  logic                           res_stall,
  output logic                           busy,
  output logic                           wr_en,
  output logic                           wr_bit,
  output logic                           res_valid,
  output logic [bmorph_pkg::PIXEL_W-1:0] pixel_out,
  output logic                           frame_last
);

  logic             s1_valid;
  bmorph_pkg::tag_t s1_tag;
  logic             s1_fire;
  logic             out_free;
  // win[col][row]: col 0 oldest .. 2 newest, row 0 top .. 2 bottom
  logic [2:0][2:0]  win;
  logic [2:0][2:0]  nb;
  logic [2:0]       new_col;
  logic [8:0]       nb_flat;
  logic [8:0]       use_bit;
  logic             result;

  assign out_free = !res_valid || !res_stall;
  assign s1_fire  = s1_valid && out_free;
  assign busy     = s1_valid && !s1_fire;
  assign wr_en    = s1_fire;
  assign wr_bit   = s1_tag.bit_set;

  assign new_col = {s1_tag.bit_set, rd_above, rd_two};
  assign nb      = {new_col, win[2], win[1]};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        nb_flat[3*c+r] = nb[c][r];
        use_bit[3*c+r] = (eight_connected || r == 1 || c == 1)
                         && !(s1_tag.edge_top && r == 0)
                         && !(s1_tag.edge_bottom && r == 2)
                         && !(s1_tag.edge_left && c == 0)
                         && !(s1_tag.edge_right && c == 2);
      end
    end
    if (op_mode == bmorph_pkg::OP_ERODE) begin
      result = &(~use_bit | nb_flat);
    end else begin
      result = |(use_bit & nb_flat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_tag <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win <= '0;
    end else if (s1_fire) begin
      win <= s1_tag.last ? '0 : nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid && s1_tag.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pixel_out  <= result ? bmorph_pkg::PIXEL_SET : bmorph_pkg::PIXEL_CLEAR;
      frame_last <= s1_tag.last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !s1_valid || s1_fire)
    else $error("window stage overwritten while holding an item");

  a_binary_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pixel_out == bmorph_pkg::PIXEL_CLEAR || pixel_out == bmorph_pkg::PIXEL_SET))
    else $error("result pixel not binary");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_tag.last |=> win == '0)
    else $error("window not cleared after frame end");

endmodule

// File: design/binary_morphology_3x3.sv
// Binary 3x3 erosion/dilation top level: configuration registers and stage wiring.
//
// Takes one item per clock while res_stall is low, with no bubbles; a stalled
// result can raise pix_stall. Each item is classified by the scan counters in
// the cycle it is accepted (which also issues the line buffer read) and is
// registered in the window stage; once the result register is free the 3x3
// window shifts, the element is evaluated and the answer lands in the result
// register. In stream terms results trail the pixels by image_width+1 items,
// and image_width+1 drain items after the last pixel flush the final row. The
// line buffers are one MAX_WIDTH x 2-bit memory with one read and one write
// per cycle; they need no clearing after reset. cfg_ready is always high; a
// width or height write restarts the frame, mode writes act immediately.
module binary_morphology_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bmorph_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  logic                                 req_type,
  input  logic [bmorph_pkg::PIXEL_W-1:0]       pixel_in,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [bmorph_pkg::PIXEL_W-1:0]       pixel_out,
  output logic                                 frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RESET_W_LAST =
    (bmorph_pkg::WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : bmorph_pkg::WIDTH_RESET) - 1;

  logic                                 cfg_write;
  logic [bmorph_pkg::WIDTH_REG_W-1:0]   width_val;
  logic [bmorph_pkg::HEIGHT_W-1:0]      height_val;
  logic [CW-1:0]                        w_last;
  logic [CW-1:0]                        w_last_next;
  logic [bmorph_pkg::HEIGHT_W-1:0]      h_eff;
  logic [bmorph_pkg::HEIGHT_W-1:0]      h_eff_next;
  logic                                 op_mode;
  logic                                 eight_connected;
  logic                                 restart;
  logic                                 accept;
  logic                                 load;
  logic [CW-1:0]                        rd_addr;
  bmorph_pkg::tag_t                     tag;
  logic                                 rd_two;
  logic                                 rd_above;
  logic                                 wr_en;
  logic                                 wr_bit;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign width_val  = cfg_data[bmorph_pkg::WIDTH_REG_W-1:0];
  assign height_val = cfg_data[bmorph_pkg::HEIGHT_W-1:0];
  assign restart    = cfg_write && ((cfg_index == bmorph_pkg::CFG_IMAGE_WIDTH)
                                 || (cfg_index == bmorph_pkg::CFG_IMAGE_HEIGHT));
  assign accept     = pix_valid && !pix_stall;

  // Width is kept as its last column index, clamped to the buffer size.
  always_comb begin
    if (width_val == '0) begin
      w_last_next = '0;
    end else if (32'(width_val) > 32'(MAX_WIDTH)) begin
      w_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_next = CW'(width_val - 11'd1);
    end
    h_eff_next = (height_val == '0) ? 16'd1 : height_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last          <= CW'(RESET_W_LAST);
      h_eff           <= 16'(bmorph_pkg::HEIGHT_RESET);
      op_mode         <= bmorph_pkg::OP_ERODE;
      eight_connected <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmorph_pkg::CFG_IMAGE_WIDTH:     w_last          <= w_last_next;
        bmorph_pkg::CFG_IMAGE_HEIGHT:    h_eff           <= h_eff_next;
        bmorph_pkg::CFG_OP_MODE:         op_mode         <= cfg_data[0];
        bmorph_pkg::CFG_EIGHT_CONNECTED: eight_connected <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bmorph_scan #(
    .CW (CW)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .restart  (restart),
    .req_type (req_type),
    .pixel_in (pixel_in),
    .w_last   (w_last),
    .h_eff    (h_eff),
    .load     (load),
    .rd_addr  (rd_addr),
    .tag      (tag)
  );

  bmorph_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_line_buf (
    .clk      (clk),
    .rd_en    (load),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_bit   (wr_bit),
    .rd_two   (rd_two),
    .rd_above (rd_above)
  );

  bmorph_window u_window (
    .clk             (clk),
    .rst             (rst),
    .load            (load),
    .tag             (tag),
    .restart         (restart),
    .rd_two          (rd_two),
    .rd_above        (rd_above),
    .op_mode         (op_mode),
    .eight_connected (eight_connected),
    .res_stall       (res_stall),
    .busy            (pix_stall),
    .wr_en           (wr_en),
    .wr_bit          (wr_bit),
    .res_valid       (res_valid),
    .pixel_out       (pixel_out),
    .frame_last      (frame_last)
  );

endmodule

// File: tb/tb_binary_morphology_3x3.sv
// Self-checking testbench for the 3x3 binary erosion/dilation stream block.
module tb_binary_morphology_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS      = 1024;
  localparam int IDLE_PCT      = 19;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 1050;

  typedef struct packed {
    logic [bmorph_pkg::PIXEL_W-1:0] pixel;
    logic                           last;
  } morph_result_t;

  typedef struct {
    bmorph_pkg::cfg_reg_t              idx;
    logic [bmorph_pkg::CFG_DATA_W-1:0] data;
  } cfg_write_t;

  logic                               clk;
  logic                               rst       = 1'b1;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [bmorph_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bmorph_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                               pix_valid = 1'b0;
  logic                               pix_stall;
  logic                               req_type  = bmorph_pkg::REQ_PIXEL;
  logic [bmorph_pkg::PIXEL_W-1:0]     pixel_in  = '0;
  logic                               res_valid;
  logic                               res_stall = 1'b0;
  logic [bmorph_pkg::PIXEL_W-1:0]     pixel_out;
  logic                               frame_last;

  binary_morphology_3x3 #(.MAX_WIDTH(MAX_COLS)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .req_type   (req_type),
    .pixel_in   (pixel_in),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor state
  logic [bmorph_pkg::WIDTH_REG_W-1:0] width_reg;
  logic [bmorph_pkg::HEIGHT_W-1:0]    height_reg;
  logic                               op_sel;
  logic                               square_sel;
  bit                                 row_buf1 [MAX_COLS];
  bit                                 row_buf2 [MAX_COLS];
  bit                                 win [3][3];
  int unsigned                        scan_col, scan_row, emit_col, emit_row;

  morph_result_t pending_pixels [$];
  cfg_write_t    reg_batch [$];

  logic        idle_on      = 1'b1;
  logic        must_rewrite = 1'b0;
  int unsigned errors, items_taken, items_ignored, results_seen, frames_seen, cfg_writes;
  int unsigned quiet_cycles;

  function automatic void restart_scan();
    scan_col = 0;
    scan_row = 0;
    emit_col = 0;
    emit_row = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = 1'b0;
  endfunction

  function automatic int unsigned cur_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned cur_height();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  // Element centered on window column cc; out-of-image neighbors are skipped.
  function automatic logic element_hit(int cc, int unsigned w, int unsigned h);
    logic erode;
    logic acc;
    erode = (op_sel == bmorph_pkg::OP_ERODE);
    acc = erode;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (!square_sel && dr != 0 && dc != 0) continue;
        if (dr < 0 && emit_row == 0) continue;
        if (dr > 0 && emit_row + 1 >= h) continue;
        if (dc < 0 && emit_col == 0) continue;
        if (dc > 0 && (emit_col + 1 >= w || cc >= 2)) continue;
        if (erode) acc = acc & win[1+dr][cc+dc];
        else acc = acc | win[1+dr][cc+dc];
      end
    end
    return acc;
  endfunction

  // Advances the predictor by one item; returns 0 when the item is ignored.
  function automatic logic morph_predict(logic rt, logic [bmorph_pkg::PIXEL_W-1:0] px);
    int unsigned w, h, c, r;
    logic draining, bit_in, top, mid, res, have, lst;
    morph_result_t exp_res;
    w = cur_width();
    h = cur_height();
    draining = scan_row >= h;
    if (rt == bmorph_pkg::REQ_DRAIN && !draining) return 1'b0;
    bit_in = !draining && px == bmorph_pkg::PIXEL_SET;
    c = scan_col;
    r = scan_row;
    res = 1'b0;
    have = 1'b0;
    // end of the row two above completes at the start of each row
    if (c == 0 && r >= 2) begin
      emit_row = r - 2;
      emit_col = w - 1;
      res = element_hit(2, w, h);
      have = 1'b1;
    end
    top = row_buf2[c];
    mid = row_buf1[c];
    row_buf2[c] = mid;
    row_buf1[c] = bit_in;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bit_in;
    if (c >= 1 && r >= 1) begin
      emit_row = r - 1;
      emit_col = c - 1;
      res = element_hit(1, w, h);
      have = 1'b1;
    end
    if (c + 1 >= w) begin
      scan_col = 0;
      scan_row = r + 1;
    end else begin
      scan_col = c + 1;
    end
    if (have) begin
      lst = (emit_row == h - 1) && (emit_col == w - 1);
      exp_res.pixel = res ? bmorph_pkg::PIXEL_SET : bmorph_pkg::PIXEL_CLEAR;
      exp_res.last  = lst;
      pending_pixels = {pending_pixels, exp_res};
      if (lst) restart_scan();
    end
    return 1'b1;
  endfunction

  function automatic void queue_reg(bmorph_pkg::cfg_reg_t idx,
                                    logic [bmorph_pkg::CFG_DATA_W-1:0] data);
    cfg_write_t wr;
    wr.idx  = idx;
    wr.data = data;
    reg_batch = {reg_batch, wr};
  endfunction

  // Single-bit register value with junk in the unused upper bits.
  function automatic logic [bmorph_pkg::CFG_DATA_W-1:0] mode_word(logic val);
    logic [bmorph_pkg::CFG_DATA_W-1:0] word;
    word = 16'($urandom());
    word[0] = val;
    return word;
  endfunction

  function automatic logic [bmorph_pkg::PIXEL_W-1:0] pick_pixel(int unsigned density);
    if ($urandom_range(99) < density) return bmorph_pkg::PIXEL_SET;
    case ($urandom_range(3))
      0: return bmorph_pkg::PIXEL_CLEAR;
      1: return 8'd254;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic program_regs();
    cfg_write_t wr;
    // registers change only with nothing in flight
    if (reg_batch.size() != 0) settle();
    while (reg_batch.size() != 0) begin
      wr = reg_batch.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.data;
      do @(posedge clk); while (!cfg_ready);
      case (wr.idx)
        bmorph_pkg::CFG_IMAGE_WIDTH: begin
          width_reg = wr.data[bmorph_pkg::WIDTH_REG_W-1:0];
          restart_scan();
        end
        bmorph_pkg::CFG_IMAGE_HEIGHT: begin
          height_reg = wr.data[bmorph_pkg::HEIGHT_W-1:0];
          restart_scan();
        end
        bmorph_pkg::CFG_OP_MODE:         op_sel = wr.data[0];
        bmorph_pkg::CFG_EIGHT_CONNECTED: square_sel = wr.data[0];
        default: ;
      endcase
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic rt, logic [bmorph_pkg::PIXEL_W-1:0] px);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    req_type  <= rt;
    pixel_in  <= px;
    do @(posedge clk); while (pix_stall);
    if (morph_predict(rt, px)) items_taken++;
    else items_ignored++;
  endtask

  // Stop sending, let every predicted result arrive, then cover the pipeline.
  task automatic settle();
    pix_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drain ticks right after reset are ignored: no row has been received.
  task automatic test_reset_drains();
    send_item(bmorph_pkg::REQ_DRAIN, 8'hFF);
    send_item(bmorph_pkg::REQ_DRAIN, 8'h00);
    settle();
  endtask

  task automatic test_directed_frames();
    queue_reg(bmorph_pkg::CFG_IMAGE_WIDTH, 16'd3);
    queue_reg(bmorph_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    queue_reg(bmorph_pkg::CFG_OP_MODE, {15'd0, bmorph_pkg::OP_ERODE});
    queue_reg(bmorph_pkg::CFG_EIGHT_CONNECTED, 16'd0);
    program_regs();
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_DRAIN, 8'd255);   // early drain, ignored
    send_item(bmorph_pkg::REQ_PIXEL, 8'd254);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd128);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd0);
    send_item(bmorph_pkg::REQ_DRAIN, 8'd0);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd1);     // past frame end, acts as drain
    send_item(bmorph_pkg::REQ_DRAIN, 8'd0);
    send_item(bmorph_pkg::REQ_DRAIN, 8'd0);
    send_item(bmorph_pkg::REQ_DRAIN, 8'd0);     // frame already flushed, ignored
    settle();
    // width 0 and height 0 both act as 1
    queue_reg(bmorph_pkg::CFG_IMAGE_WIDTH, 16'd0);
    queue_reg(bmorph_pkg::CFG_IMAGE_HEIGHT, 16'd0);
    queue_reg(bmorph_pkg::CFG_OP_MODE, {15'd0, bmorph_pkg::OP_DILATE});
    queue_reg(bmorph_pkg::CFG_EIGHT_CONNECTED, 16'd1);
    program_regs();
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_DRAIN, 8'd0);
    send_item(bmorph_pkg::REQ_DRAIN, 8'd0);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd0);
    send_item(bmorph_pkg::REQ_PIXEL, 8'd255);
    send_item(bmorph_pkg::REQ_DRAIN, 8'd7);
    settle();
  endtask

  // Tallest height with a narrow row; the frame is abandoned after a few rows.
  task automatic test_tall_abandoned();
    queue_reg(bmorph_pkg::CFG_IMAGE_WIDTH, 16'd5);
    queue_reg(bmorph_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
    queue_reg(bmorph_pkg::CFG_OP_MODE, mode_word(bmorph_pkg::OP_ERODE));
    queue_reg(bmorph_pkg::CFG_EIGHT_CONNECTED, mode_word(1'b1));
    program_regs();
    repeat (23) send_item(bmorph_pkg::REQ_PIXEL, pick_pixel(85));
    settle();
    must_rewrite = 1'b1;
  endtask

  task automatic random_frame();
    int unsigned wreg, hreg, w, h, npix, density, stop_at, tweak_at;
    logic abandon;
    logic [bmorph_pkg::CFG_DATA_W-1:0] junk;
    if (must_rewrite || $urandom_range(9) < 7) begin
      wreg = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 48);
      hreg = $urandom_range(0, 6);
      junk = 16'($urandom());
      queue_reg(bmorph_pkg::CFG_IMAGE_WIDTH, {junk[15:11], wreg[10:0]});
      queue_reg(bmorph_pkg::CFG_IMAGE_HEIGHT, hreg[15:0]);
      must_rewrite = 1'b0;
    end
    if ($urandom_range(1))
      queue_reg(bmorph_pkg::CFG_OP_MODE, mode_word(1'($urandom_range(1))));
    if ($urandom_range(1))
      queue_reg(bmorph_pkg::CFG_EIGHT_CONNECTED, mode_word(1'($urandom_range(1))));
    program_regs();

    w = cur_width();
    h = cur_height();
    npix = w * h;
    density = $urandom_range(40, 100);
    abandon = (npix > 1) && ($urandom_range(99) < 10);
    stop_at = abandon ? $urandom_range(1, npix - 1) : npix;
    tweak_at = ($urandom_range(99) < 15) ? $urandom_range(0, stop_at - 1) : npix + 1;

    for (int unsigned j = 0; j < stop_at; j++) begin
      if (j == tweak_at) begin
        // mode change in the middle of a frame, with the block idle
        settle();
        queue_reg(bmorph_pkg::CFG_OP_MODE, mode_word(1'($urandom_range(1))));
        queue_reg(bmorph_pkg::CFG_EIGHT_CONNECTED, mode_word(1'($urandom_range(1))));
        program_regs();
      end
      if ($urandom_range(99) < 5) send_item(bmorph_pkg::REQ_DRAIN, 8'($urandom()));
      send_item(bmorph_pkg::REQ_PIXEL, pick_pixel(density));
    end

    if (abandon) begin
      settle();
      must_rewrite = 1'b1;
    end else begin
      repeat (w + 1)
        send_item(($urandom_range(3) == 0) ? bmorph_pkg::REQ_PIXEL : bmorph_pkg::REQ_DRAIN,
                  8'($urandom()));
      if ($urandom_range(99) < 20)
        repeat ($urandom_range(1, 2)) send_item(bmorph_pkg::REQ_DRAIN, 8'($urandom()));
    end
  endtask

  task automatic test_random_frames();
    int unsigned start_items, frame_no;
    start_items = items_taken;
    frame_no = 0;
    while (items_taken - start_items < RANDOM_ITEMS) begin
      // a run of frames with both sides streaming at full rate
      idle_on = !(frame_no >= 8 && frame_no < 14);
      random_frame();
      frame_no++;
    end
    idle_on = 1'b1;
    settle();
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin : check_results
    morph_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: pixel_out=%0d frame_last=%0d", pixel_out, frame_last);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out !== want.pixel) begin
          $error("pixel_out mismatch: expected %0d, got %0d", want.pixel, pixel_out);
          errors++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last mismatch: expected %0d, got %0d", want.last, frame_last);
          errors++;
        end
        results_seen++;
        if (want.last) frames_seen++;
      end
    end
    res_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_pixels.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    width_reg  = 11'(bmorph_pkg::WIDTH_RESET);
    height_reg = 16'(bmorph_pkg::HEIGHT_RESET);
    op_sel     = bmorph_pkg::OP_ERODE;
    square_sel = 1'b0;
    restart_scan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_drains();
    test_directed_frames();
    test_tall_abandoned();
    test_random_frames();
    settle();

    if (pending_pixels.size() != 0) begin
      $error("%0d expected results never arrived", pending_pixels.size());
      errors++;
    end
    $display("Checked %0d result pixels in %0d finished frames from %0d items (%0d ignored),",
             results_seen, frames_seen, items_taken, items_ignored);
    $display("with %0d register writes across erode/dilate, cross/square and 1..48 widths.",
             cfg_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
